@@ hw/rtl/sfxd_pkg.sv @@
`default_nettype none

package sfxd_pkg;

    // Bytes in one keystream block (one SHA-1 digest).
    localparam int BlockLen   = 20;
    localparam int RoundCount = 80;

    // SHA-1 initial chaining values.
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // SHA-1 round constants.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;     // byte intake open
        logic load;     // build the padded message words
        logic round;    // run one compression round
        logic finish;   // add chaining values, update keystream
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_start;  // a ciphertext beat closed a block
        logic last_round;  // current round is the eightieth
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/sfxd_ctrl.sv @@
`default_nettype none

module sfxd_ctrl
    import sfxd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;

    // Sequence intake, message load, rounds and finalization
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '{idle: 1'b1, load: 1'b0, round: 1'b0, finish: 1'b0};
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (status.hash_start)
                    begin
                        state_reg <= ST_LOAD;
                        cmd_reg   <= '{idle: 1'b0, load: 1'b1, round: 1'b0, finish: 1'b0};
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_ROUND;
                    cmd_reg   <= '{idle: 1'b0, load: 1'b0, round: 1'b1, finish: 1'b0};
                end
                ST_ROUND:
                begin
                    if (status.last_round)
                    begin
                        state_reg <= ST_FINISH;
                        cmd_reg   <= '{idle: 1'b0, load: 1'b0, round: 1'b0, finish: 1'b1};
                    end
                end
                ST_FINISH:
                begin
                    state_reg <= ST_IDLE;
                    cmd_reg   <= '{idle: 1'b1, load: 1'b0, round: 1'b0, finish: 1'b0};
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    cmd_reg   <= '{idle: 1'b1, load: 1'b0, round: 1'b0, finish: 1'b0};
                end
            endcase
        end
    end

    assign cmd = cmd_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sfxd_datapath.sv @@
`default_nettype none

module sfxd_datapath
    import sfxd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    output status_t         status,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata
);

    localparam logic [4:0] LastPos   = 5'(BlockLen - 1);
    localparam logic [6:0] LastRound = 7'(RoundCount - 1);

    // Keystream and block state
    logic [7:0]  keystream_reg [BlockLen];
    logic [7:0]  block_bytes_reg [BlockLen];
    logic [4:0]  block_pos_reg;
    logic [4:0]  key_pos_reg;
    logic [4:0]  len_reg;

    // Compression state
    logic [31:0] sched_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  round_reg;

    // Output queue, two entries
    logic [7:0]  q0_reg, q1_reg;
    logic [1:0]  count_reg;

    logic        accept;
    logic        cipher_push;
    logic        pop;
    logic [7:0]  plain;
    logic [31:0] msg_words [16];
    logic [31:0] f_val, k_val, t_val, w_new;
    logic [31:0] hash_words [5];

    assign s_tready    = cmd.idle && (count_reg != 2'd2);
    assign accept      = s_tvalid && s_tready;
    assign cipher_push = accept && !s_tuser;
    assign pop         = m_tvalid && m_tready;
    assign plain       = s_tdata ^ keystream_reg[block_pos_reg];

    assign status.hash_start = cipher_push && (s_tlast || (block_pos_reg == LastPos));
    assign status.last_round = (round_reg == LastRound);

    // Track block and key positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_pos_reg <= '0;
            key_pos_reg   <= '0;
            len_reg       <= '0;
        end
        else if (accept)
        begin
            if (s_tuser)
            begin
                key_pos_reg   <= (key_pos_reg == LastPos) ? 5'd0 : key_pos_reg + 5'd1;
                block_pos_reg <= '0;
            end
            else
            begin
                key_pos_reg <= '0;
                if (status.hash_start)
                begin
                    block_pos_reg <= '0;
                    len_reg       <= block_pos_reg + 5'd1;
                end
                else
                begin
                    block_pos_reg <= block_pos_reg + 5'd1;
                end
            end
        end
    end

    // Hold ciphertext bytes of the current block
    always_ff @(posedge clk)
    begin
        if (cipher_push)
        begin
            block_bytes_reg[block_pos_reg] <= s_tdata;
        end
    end

    // Digest words: chaining value plus working variables
    assign hash_words[0] = H0_INIT + a_reg;
    assign hash_words[1] = H1_INIT + b_reg;
    assign hash_words[2] = H2_INIT + c_reg;
    assign hash_words[3] = H3_INIT + d_reg;
    assign hash_words[4] = H4_INIT + e_reg;

    // Load complemented key bytes, replace the first len keystream bytes with digest bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BlockLen; i++)
            begin
                keystream_reg[i] <= '0;
            end
        end
        else if (accept && s_tuser)
        begin
            keystream_reg[key_pos_reg] <= ~s_tdata;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < BlockLen; i++)
            begin
                if (5'(i) < len_reg)
                begin
                    keystream_reg[i] <= hash_words[i / 4][31 - 8 * (i % 4) -: 8];
                end
            end
        end
    end

    // Build padded message words from the block bytes
    always_comb
    begin
        logic [7:0] mb;
        for (int w = 0; w < 16; w++)
        begin
            msg_words[w] = '0;
        end
        for (int j = 0; j < 64; j++)
        begin
            if (j < BlockLen && 5'(j) < len_reg)
            begin
                mb = block_bytes_reg[j % BlockLen];
            end
            else if (j < 32 && 5'(j) == len_reg)
            begin
                mb = 8'h80;
            end
            else if (j == 63)
            begin
                mb = {len_reg, 3'b000};
            end
            else
            begin
                mb = '0;
            end
            msg_words[j / 4][31 - 8 * (j % 4) -: 8] = mb;
        end
    end

    // Round function and next schedule word
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        w_new = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_reg[0];
    end

    // Advance the compression one round per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            e_reg     <= '0;
            for (int i = 0; i < 16; i++)
            begin
                sched_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            round_reg <= '0;
            a_reg     <= H0_INIT;
            b_reg     <= H1_INIT;
            c_reg     <= H2_INIT;
            d_reg     <= H3_INIT;
            e_reg     <= H4_INIT;
            for (int i = 0; i < 16; i++)
            begin
                sched_reg[i] <= msg_words[i];
            end
        end
        else if (cmd.round)
        begin
            round_reg <= status.last_round ? 7'd0 : round_reg + 7'd1;
            a_reg     <= t_val;
            b_reg     <= a_reg;
            c_reg     <= {b_reg[1:0], b_reg[31:2]};
            d_reg     <= c_reg;
            e_reg     <= d_reg;
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_new;
        end
    end

    // Output queue count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cipher_push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !cipher_push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Output queue payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            q0_reg <= (cipher_push && count_reg == 2'd1) ? plain : q1_reg;
            if (cipher_push)
            begin
                q1_reg <= plain;
            end
        end
        else if (cipher_push)
        begin
            if (count_reg == 2'd0)
            begin
                q0_reg <= plain;
            end
            else
            begin
                q1_reg <= plain;
            end
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q0_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sha1_feedback_xor_decrypt_unit.sv @@
`default_nettype none

// Channel   Dir  Signals                       Contents
// s_*       in   tvalid tready tdata tuser tlast  key or ciphertext byte
// m_*       out  tvalid tready tdata           plaintext byte
//
// A key or ciphertext beat is taken while intake is open and the output
// queue has room. A ciphertext beat that closes a block (twentieth byte
// or tlast) starts a SHA-1 compression: a load step, 80 rounds and a
// finish step, while intake stays closed.
// Reset clears keystream, positions, queue and controller state.
// A two-entry output queue keeps intake going while results wait.

module sha1_feedback_xor_decrypt_unit
    import sfxd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] is_key
    input  wire logic       s_tlast,   // block_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [7:0] plain_byte
);

    cmd_t    cmd;
    status_t status;

    sfxd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sfxd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/sfxd_checker.sv @@
`default_nettype none

module sfxd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tuser,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

    // Close intake after a ciphertext beat with tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready)
    else $error("intake open after block end");

    // Show a result after a ciphertext beat into an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> m_tvalid)
    else $error("ciphertext beat produced no result");

    // Drop nothing out for a key beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("key beat produced a result");

endmodule

bind sha1_feedback_xor_decrypt_unit sfxd_checker u_sfxd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/tb_sha1_feedback_xor_decrypt_unit.sv @@
`timescale 1ns / 100ps

module tb_sha1_feedback_xor_decrypt_unit;

    localparam int BLOCK_BYTES  = 20;
    localparam int PHASE_BEATS  = 381;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 120;
    localparam int SHOWN_FAILS  = 10;

    // SHA-1 chaining values and round constants
    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;
    localparam logic [31:0] SHA_K0 = 32'h5A827999;
    localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [7:0] data;
        logic       key;
        logic       last;
        logic       typed;   // plain below is the expected byte
        logic [7:0] plain;
    } dir_row_t;

    // Directed beats: plaintext typed where the pad is obvious
    localparam dir_row_t DIR_TABLE [27] = '{
        // after reset the pad is all zero
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF},
        // key load drops the open block; tlast on a key byte is ignored
        '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'hA5, 1'b1, 1'b1, 1'b0, 8'h00},
        // full block, pad bytes 0..2 come from the key, the rest still zero
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'hFF},
        '{8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF},
        '{8'h0F, 1'b0, 1'b0, 1'b1, 8'h55},
        '{8'h12, 1'b0, 1'b0, 1'b1, 8'h12},
        '{8'h34, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h56, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h78, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h9A, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hBC, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hDE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h23, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h45, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h67, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h89, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hAB, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hCD, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hEF, 1'b0, 1'b0, 1'b0, 8'h00},
        // twentieth byte with tlast closes the block once
        '{8'h80, 1'b0, 1'b1, 1'b0, 8'h00},
        // one-byte short block, then the first byte of the next
        '{8'h80, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h3C, 1'b0, 1'b0, 1'b0, 8'h00}
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tuser  = 1'b0;    // [0] is_key
    logic       s_tlast  = 1'b0;    // block_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] plain_byte

    // Predictor state
    logic [7:0] pad_bytes  [BLOCK_BYTES] = '{default: 8'h00};
    logic [7:0] cipher_buf [BLOCK_BYTES] = '{default: 8'h00};
    int         cipher_pos = 0;
    int         key_fill   = 0;
    logic [7:0] pending_plain [$];

    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int n_beats       = 0;
    int n_keys        = 0;
    int n_blocks      = 0;
    int n_checked     = 0;
    int n_failures    = 0;

    sha1_feedback_xor_decrypt_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // SHA-1 over the first len bytes of the cipher buffer, one padded block
    function automatic logic [159:0] sha1_digest(input int len);
        logic [7:0]  msg [64];
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, bits;
        for (int i = 0; i < 64; i++)
            msg[i] = 8'h00;
        for (int i = 0; i < len; i++)
            msg[i] = cipher_buf[i];
        msg[len] = 8'h80;
        bits = 32'(len * 8);
        msg[62] = bits[15:8];
        msg[63] = bits[7:0];
        for (int i = 0; i < 16; i++)
            w[i] = {msg[4 * i], msg[4 * i + 1], msg[4 * i + 2], msg[4 * i + 3]};
        for (int i = 16; i < 80; i++)
        begin
            t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {t[30:0], t[31]};
        end
        a = SHA_H0;
        b = SHA_H1;
        c = SHA_H2;
        d = SHA_H3;
        e = SHA_H4;
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = SHA_K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = SHA_K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = SHA_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = SHA_K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        return {SHA_H0 + a, SHA_H1 + b, SHA_H2 + c, SHA_H3 + d, SHA_H4 + e};
    endfunction

    // Advance the predictor by one accepted beat; returns 1 with a plaintext byte
    function automatic bit decrypt_beat(input logic [7:0] data, input logic key,
                                        input logic last, output logic [7:0] plain);
        logic [159:0] digest;
        plain = 8'h00;
        if (key)
        begin
            pad_bytes[key_fill] = ~data;
            key_fill = (key_fill + 1) % BLOCK_BYTES;
            cipher_pos = 0;
            n_keys++;
            return 1'b0;
        end
        key_fill = 0;
        plain = data ^ pad_bytes[cipher_pos];
        cipher_buf[cipher_pos] = data;
        cipher_pos++;
        if (cipher_pos == BLOCK_BYTES || last)
        begin
            digest = sha1_digest(cipher_pos);
            for (int i = 0; i < cipher_pos; i++)
                pad_bytes[i] = digest[159 - 8 * i -: 8];
            cipher_pos = 0;
            n_blocks++;
        end
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        n_failures++;
        if (n_failures <= SHOWN_FAILS)
            $display("%t: %s", $realtime, msg);
    endtask

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input logic [7:0] data, input logic key, input logic last,
                             input logic typed, input logic [7:0] typed_plain);
        logic [7:0] plain;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= key;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_beats++;
        if (decrypt_beat(data, key, last, plain))
            pending_plain.push_back(typed ? typed_plain : plain);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // Compare plaintext beats and drive the stall pattern
    initial
    begin : plain_sink
        int         hold_left;
        int         holds_done;
        logic [7:0] want;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                n_checked++;
                if (pending_plain.size() == 0)
                    note_failure($sformatf("unexpected plaintext beat %02h", m_tdata));
                else
                begin
                    want = pending_plain.pop_front();
                    if (m_tdata !== want)
                        note_failure($sformatf("plaintext mismatch: expected %02h, got %02h",
                                               want, m_tdata));
                end
            end
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run when no beat moves on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int kind;
        int len;
        int r;
        int phase_end;
        bit first;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (DIR_TABLE[i])
            send_beat(DIR_TABLE[i].data, DIR_TABLE[i].key, DIR_TABLE[i].last,
                      DIR_TABLE[i].typed, DIR_TABLE[i].plain);

        // Random phases: none, sender gaps, receiver stalls, light mix
        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    gap_pct   = 7;
                    stall_pct = 7;
                end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (ph == 0)
                hold_requests++;
            phase_end = n_beats + PHASE_BEATS;
            first = 1'b1;
            while (n_beats < phase_end)
            begin
                kind = first ? 0 : $urandom_range(99);
                first = 1'b0;
                if (kind < 12)
                begin
                    // key load: mostly full, some short, some wrapping past 20
                    r = $urandom_range(99);
                    len = (r < 70) ? BLOCK_BYTES :
                          (r < 85) ? $urandom_range(1, BLOCK_BYTES - 1) :
                                     $urandom_range(BLOCK_BYTES + 1, BLOCK_BYTES + 6);
                    for (int i = 0; i < len; i++)
                        send_beat(pick_byte(), 1'b1, 1'($urandom_range(1)), 1'b0, 8'h00);
                end
                else if (kind < 85)
                begin
                    // ciphertext block: full with or without tlast, or short
                    r = $urandom_range(99);
                    len = (r < 45) ? BLOCK_BYTES : $urandom_range(1, BLOCK_BYTES - 1);
                    for (int i = 0; i < len; i++)
                        send_beat(pick_byte(), 1'b0,
                                  (i == len - 1) && (len < BLOCK_BYTES || r < 22),
                                  1'b0, 8'h00);
                end
                else
                begin
                    // noise: loose beats of either kind
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        send_beat(pick_byte(), $urandom_range(3) == 0,
                                  1'($urandom_range(1)), 1'b0, 8'h00);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding plaintext, then let a running hash finish
        while (pending_plain.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d beats driven (%0d key bytes), %0d plaintext beats compared",
                 n_beats, n_keys, n_checked);
        $display("summary: %0d blocks hashed over four idle mixes and a %0d-cycle hold-off",
                 n_blocks, HOLD_CYCLES);
        if (n_failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
